/* hw/rtl/wfg_pkg.sv */
// Shared types, codes and constants of the waveform generator.
// No dependencies; every other RTL file imports this package.
`default_nettype none
package wfg_pkg;

  localparam int DUTY_MAX     = 1000;
  localparam int PHASE_MAX    = 3600;
  localparam int MAX_RESULTS  = 40;
  localparam int GROUP_STRIDE = 16;
  localparam logic [3:0] BIT_MASK = 4'hF;
  localparam int DIVW = 32;

  // phase*period/3600 = ((x >> 4) * PRESET_RECIP) >> 32, exact for x below 2^28
  localparam logic [24:0] PRESET_RECIP = 25'd19088744;

  // request codes
  localparam logic [1:0] REQ_REG  = 2'd0;
  localparam logic [1:0] REQ_CHG  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // wave kinds
  localparam logic [2:0] KIND_SINE  = 3'd0;
  localparam logic [2:0] KIND_PULSE = 3'd1;
  localparam logic [2:0] KIND_UP    = 3'd2;
  localparam logic [2:0] KIND_DOWN  = 3'd3;
  localparam logic [2:0] KIND_TRI   = 3'd4;

  // acknowledgment status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DUTY_BAD  = 3'd2;
  localparam logic [2:0] ST_PHASE_BAD = 3'd3;
  localparam logic [2:0] ST_BOTH_BAD  = 3'd4;
  localparam logic [2:0] ST_RANGE     = 3'd5;
  localparam logic [2:0] ST_UNUSED    = 3'd6;

  typedef enum logic [1:0] {WR_REG, WR_CHG, WR_TICK} wr_sel_t;
  typedef enum logic [1:0] {DIV_DUE, DIV_SAMPLE} div_op_t;

  typedef struct packed {
    logic [15:0] amp;
    logic [15:0] step;
    logic [15:0] period;
    logic [9:0]  duty;
    logic [7:0]  sig;
    logic [15:0] cnt;
  } slot_word_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    ack;
    logic    set_used;
    logic    mem_rd;
    logic    rd_tick;
    logic    mem_wr;
    wr_sel_t wr_sel;
    logic    div_start;
    div_op_t div_op;
    logic    tick_init;
    logic    cnt_ld;
    logic    mul;
    logic    rom_rd;
    logic    smul;
    logic    push;
    logic    flush;
    logic    advance;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req;
    logic       reg_ok;
    logic       chg_ok;
    logic       used_cur;
    logic       step_zero;
    logic       cnt_zero;
    logic       zero_period;
    logic       div_done;
    logic       rem_zero;
    logic       cap;
    logic       sine;
    logic       last_slot;
  } sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) return 16'sh7FFF;
    if (v < -34'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/wfg_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wfg_pkg for the dividend width.
`default_nettype none
module wfg_div import wfg_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [DIVW-1:0] num,
  input  wire logic [15:0]     den,
  output logic                 done,
  output logic [DIVW-1:0]      quo,
  output logic [15:0]          rem
);

  logic [5:0]  cnt;
  logic        running;
  logic [15:0] den_q;
  logic [16:0] trial;

  assign trial = {rem, quo[DIVW-1]};

  // shift in one dividend bit and subtract where it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo     <= num;
        rem     <= '0;
        den_q   <= den;
        cnt     <= 6'(DIVW);
        running <= 1'b1;
      end else if (running) begin
        if (trial >= {1'b0, den_q}) begin
          rem <= 16'(trial - {1'b0, den_q});
          quo <= {quo[DIVW-2:0], 1'b1};
        end else begin
          rem <= trial[15:0];
          quo <= {quo[DIVW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/wfg_datapath.sv */
// Slot store, used masks, sine table, divider and result registers.
// Depends on wfg_pkg and wfg_div; driven by wfg_ctrl through cmd_t.
`default_nettype none
module wfg_datapath import wfg_pkg::*; #(
  parameter int SLOTS_PER_GROUP = 8,
  parameter int GROUPS          = 1,
  parameter int WAVE_KINDS      = 5,
  parameter int SINE_POINTS     = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  req_type,
  input  wire logic [2:0]  wave_kind,
  input  wire logic [5:0]  slot_index,
  input  wire logic [15:0] amplitude,
  input  wire logic [15:0] step,
  input  wire logic [15:0] period,
  input  wire logic [9:0]  duty,
  input  wire logic [11:0] phase,
  input  wire logic [7:0]  signal_id,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  output logic             strobe,
  output logic             result_kind,
  output logic [2:0]       out_kind,
  output logic [5:0]       out_slot,
  output logic [7:0]       out_signal,
  output logic [15:0]      sample_value,
  output logic [2:0]       status,
  output logic             last
);

  localparam int SLOTS = WAVE_KINDS * GROUPS * SLOTS_PER_GROUP;
  localparam int POOLS = WAVE_KINDS * GROUPS;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int BW = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int IW = (SINE_POINTS > 1) ? $clog2(SINE_POINTS) : 1;
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // quarter-wave series, rounded to Q1.15
  function automatic logic signed [15:0] sine_entry(input int i);
    longint unsigned four, q, r, x, x2, t, s, v;
    four = 64'(4) * longint'(i);
    q    = four / SINE_POINTS;
    r    = four - q * SINE_POINTS;
    if (q[0]) r = SINE_POINTS - r;
    x  = HALF_PI_Q30 * r / SINE_POINTS;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    v  = (s + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return (q >= 2) ? -16'(v) : 16'(v);
  endfunction

  logic signed [15:0] rom_tab [SINE_POINTS];
  for (genvar i = 0; i < SINE_POINTS; i++) begin : g_rom
    assign rom_tab[i] = sine_entry(i);
  end

  // latched request
  logic [1:0]  q_req;
  logic [2:0]  q_kind;
  logic [5:0]  q_sidx;
  logic [15:0] q_amp, q_step, q_period;
  logic [9:0]  q_duty;
  logic [11:0] q_phase;
  logic [7:0]  q_sig;

  logic [SLOTS_PER_GROUP-1:0] used [POOLS];
  slot_word_t mem [SLOTS];
  slot_word_t rd_q, wr_data;
  logic [SW-1:0] rd_addr, wr_addr, reg_addr, chg_addr;
  logic [PW-1:0] reg_pool, tk_pool;
  logic [BW-1:0] reg_bit;

  logic       kind_ok, reg_found, grp_ok, bit_ok, duty_ok, phase_ok;
  logic [1:0] chg_g;
  logic [3:0] chg_b;
  logic [2:0] pstat, ack_st;
  logic [5:0] ack_slot;
  logic [7:0] ack_sig;
  int         rg, rb;

  // change preset
  logic [27:0] pre_prod;
  logic [48:0] pre_wide;
  logic [15:0] pre_cnt;

  // tick walk
  logic [SW-1:0] tk_s;
  logic [2:0]    tk_k;
  logic [GW-1:0] tk_g;
  logic [BW-1:0] tk_b;
  logic [5:0]    n_out;
  logic [15:0]   c1, c_new, cur_c;

  // arithmetic stages
  logic [DIVW-1:0] div_num, div_quo, mul_mag;
  logic [15:0]     div_den, div_rem, mul_den;
  logic            div_done, mul_neg;
  logic [16:0]     abs_a, xsel;
  logic [33:0]     ax;
  logic signed [15:0] rom_q;
  logic signed [31:0] sprod;
  logic signed [32:0] srnd;
  logic signed [33:0] fin_v;
  logic [15:0]     fin_val;

  logic       pend_v;
  logic [2:0] pend_kind;
  logic [5:0] pend_slot;
  logic [7:0] pend_sig;
  logic [15:0] pend_val;

  // latch the request on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_req    <= req_type;
      q_kind   <= wave_kind;
      q_sidx   <= slot_index;
      q_amp    <= amplitude;
      q_step   <= step;
      q_period <= period;
      q_duty   <= duty;
      q_phase  <= phase;
      q_sig    <= signal_id;
    end
  end

  // decode register and change requests
  always_comb begin
    kind_ok   = int'(q_kind) < WAVE_KINDS;
    reg_found = 1'b0;
    rg = 0;
    rb = 0;
    for (int g = 0; g < GROUPS; g++) begin
      if (kind_ok && !reg_found && (used[PW'(int'(q_kind) * GROUPS + g)] != '1)) begin
        reg_found = 1'b1;
        rg = g;
      end
    end
    reg_pool = PW'(int'(q_kind) * GROUPS + rg);
    for (int b = SLOTS_PER_GROUP - 1; b >= 0; b--) begin
      if (!used[reg_pool][b]) rb = b;
    end
    reg_bit  = BW'(rb);
    reg_addr = SW'((int'(q_kind) * GROUPS + rg) * SLOTS_PER_GROUP + rb);

    chg_g  = q_sidx[5:4];
    chg_b  = q_sidx[3:0] & BIT_MASK;
    grp_ok = kind_ok && (int'(chg_g) < GROUPS);
    bit_ok = grp_ok && (int'(chg_b) < SLOTS_PER_GROUP) &&
             used[PW'(int'(q_kind) * GROUPS + int'(chg_g))][BW'(chg_b)];
    chg_addr = SW'((int'(q_kind) * GROUPS + int'(chg_g)) * SLOTS_PER_GROUP + int'(chg_b));

    duty_ok  = int'(q_duty) <= DUTY_MAX;
    phase_ok = int'(q_phase) <= PHASE_MAX;
    if (!duty_ok && !phase_ok) pstat = ST_BOTH_BAD;
    else if (!duty_ok)         pstat = ST_DUTY_BAD;
    else if (!phase_ok)        pstat = ST_PHASE_BAD;
    else                       pstat = ST_OK;

    ack_slot = 6'd0;
    ack_sig  = 8'd0;
    if (q_req == REQ_REG) begin
      if (!kind_ok)        ack_st = ST_RANGE;
      else if (!reg_found) ack_st = ST_FULL;
      else begin
        ack_st   = pstat;
        ack_slot = 6'(rg * GROUP_STRIDE + rb);
        ack_sig  = q_sig;
      end
    end else begin
      ack_slot = q_sidx;
      if (!grp_ok)      ack_st = ST_RANGE;
      else if (!bit_ok) ack_st = ST_UNUSED;
      else begin
        ack_st  = pstat;
        ack_sig = rd_q.sig;
      end
    end
  end

  // mark a newly taken slot
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < POOLS; p++) used[p] <= '0;
    end else if (cmd.set_used) begin
      used[reg_pool][reg_bit] <= 1'b1;
    end
  end

  // change preset: phase times period, then divide by 3600 through a reciprocal
  assign pre_wide = 49'(pre_prod[27:4]) * 49'(PRESET_RECIP);

  always_ff @(posedge clk) begin
    pre_prod <= 28'(q_phase) * 28'(q_period);
    pre_cnt  <= pre_wide[47:32];
  end

  // slot store: one write and one registered read per cycle
  assign c1    = rd_q.cnt + 16'd1;
  assign c_new = (c1 >= rd_q.period) ? 16'd0 : c1;

  always_comb begin
    wr_data = rd_q;
    wr_addr = tk_s;
    unique case (cmd.wr_sel)
      WR_REG: begin
        wr_addr = reg_addr;
        wr_data = '{amp: q_amp, step: q_step, period: q_period,
                    duty: duty_ok ? q_duty : 10'd0, sig: q_sig, cnt: 16'd0};
      end
      WR_CHG: begin
        wr_addr = chg_addr;
        wr_data = '{amp: q_amp, step: q_step, period: q_period,
                    duty: duty_ok ? q_duty : rd_q.duty, sig: rd_q.sig,
                    cnt: pre_cnt};
      end
      default: wr_data.cnt = c_new;
    endcase
  end

  assign rd_addr = cmd.rd_tick ? tk_s : chg_addr;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[wr_addr] <= wr_data;
    if (cmd.mem_rd) rd_q <= mem[rd_addr];
  end

  // walk slots in kind, group, bit order
  assign tk_pool = PW'(int'(tk_k) * GROUPS + int'(tk_g));

  always_ff @(posedge clk) begin
    if (rst) begin
      tk_s  <= '0;
      tk_k  <= '0;
      tk_g  <= '0;
      tk_b  <= '0;
      n_out <= '0;
    end else if (cmd.tick_init) begin
      tk_s  <= '0;
      tk_k  <= '0;
      tk_g  <= '0;
      tk_b  <= '0;
      n_out <= '0;
    end else begin
      if (cmd.push) n_out <= n_out + 6'd1;
      if (cmd.advance) begin
        tk_s <= tk_s + SW'(1);
        if (tk_b == BW'(SLOTS_PER_GROUP - 1)) begin
          tk_b <= '0;
          if (tk_g == GW'(GROUPS - 1)) begin
            tk_g <= '0;
            tk_k <= tk_k + 3'd1;
          end else begin
            tk_g <= tk_g + GW'(1);
          end
        end else begin
          tk_b <= tk_b + BW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_ld) cur_c <= c_new;
  end

  // operand stage ahead of the divider
  always_comb begin
    abs_a = rd_q.amp[15] ? (~{1'b1, rd_q.amp} + 17'd1) : {1'b0, rd_q.amp};
    unique case (tk_k)
      KIND_UP:   xsel = {1'b0, cur_c};
      KIND_DOWN: xsel = {1'b0, rd_q.period} - {1'b0, cur_c};
      default: begin
        if (cur_c < (rd_q.period >> 1)) xsel = {cur_c, 1'b0};
        else xsel = {rd_q.period - cur_c, 1'b0};
      end
    endcase
    ax = abs_a * xsel;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      mul_den <= rd_q.period;
      mul_neg <= rd_q.amp[15] && (xsel != 17'd0);
      unique case (tk_k)
        KIND_SINE:  mul_mag <= DIVW'(cur_c) * DIVW'(SINE_POINTS);
        KIND_PULSE: mul_mag <= DIVW'(rd_q.duty) * DIVW'(rd_q.period);
        default:    mul_mag <= ax[DIVW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cmd.div_op)
      DIV_DUE: begin
        div_num = DIVW'(cur_c);
        div_den = rd_q.step;
      end
      default: begin
        div_num = mul_mag;
        div_den = mul_den;
      end
    endcase
  end

  wfg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // sine lookup and scaling
  always_ff @(posedge clk) begin
    if (cmd.rom_rd) rom_q <= rom_tab[div_quo[IW-1:0]];
    if (cmd.smul)   sprod <= $signed(rd_q.amp) * rom_q;
  end

  // finish the sample; pulse is high while 1000*(c+1) <= duty*period
  always_comb begin
    srnd = 33'(sprod) + 33'sd16384;
    if (rd_q.period == 16'd0) begin
      fin_v = '0;
    end else begin
      unique case (tk_k)
        KIND_SINE:  fin_v = 34'(srnd >>> 15);
        KIND_PULSE: fin_v = (DIVW'(cur_c) * DIVW'(DUTY_MAX) + DIVW'(DUTY_MAX) <= mul_mag) ?
                            34'($signed(rd_q.amp)) : '0;
        default:    fin_v = mul_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
      endcase
    end
    fin_val = sat16(fin_v);
  end

  // result registers: acks go out at once, samples through a one-deep hold
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      pend_v <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.ack) begin
        strobe       <= 1'b1;
        result_kind  <= 1'b0;
        out_kind     <= q_kind;
        out_slot     <= ack_slot;
        out_signal   <= ack_sig;
        sample_value <= 16'd0;
        status       <= ack_st;
        last         <= 1'b1;
      end else if (cmd.push) begin
        if (pend_v) begin
          strobe       <= 1'b1;
          result_kind  <= 1'b1;
          out_kind     <= pend_kind;
          out_slot     <= pend_slot;
          out_signal   <= pend_sig;
          sample_value <= pend_val;
          status       <= ST_OK;
          last         <= 1'b0;
        end
        pend_v    <= 1'b1;
        pend_kind <= tk_k;
        pend_slot <= 6'(int'(tk_g) * GROUP_STRIDE + int'(tk_b));
        pend_sig  <= rd_q.sig;
        pend_val  <= fin_val;
      end else if (cmd.flush) begin
        if (pend_v) begin
          strobe       <= 1'b1;
          result_kind  <= 1'b1;
          out_kind     <= pend_kind;
          out_slot     <= pend_slot;
          out_signal   <= pend_sig;
          sample_value <= pend_val;
          status       <= ST_OK;
          last         <= 1'b1;
        end
        pend_v <= 1'b0;
      end
    end
  end

  // status toward the controller
  always_comb begin
    sts.req         = q_req;
    sts.reg_ok      = kind_ok && reg_found;
    sts.chg_ok      = bit_ok;
    sts.used_cur    = used[tk_pool][tk_b];
    sts.step_zero   = rd_q.step == 16'd0;
    sts.cnt_zero    = cur_c == 16'd0;
    sts.zero_period = rd_q.period == 16'd0;
    sts.div_done    = div_done;
    sts.rem_zero    = div_rem == 16'd0;
    sts.cap         = int'(n_out) >= MAX_RESULTS;
    sts.sine        = tk_k == KIND_SINE;
    sts.last_slot   = tk_s == SW'(SLOTS - 1);
  end

endmodule
`default_nettype wire

/* hw/rtl/wfg_ctrl.sv */
// Sequencer for register, change and tick requests.
// Depends on wfg_pkg; issues cmd_t to wfg_datapath and reads sts_t.
`default_nettype none
module wfg_ctrl import wfg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire sts_t sts,
  output logic      busy,
  output cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CHG_SCALE, S_CHG_WR, S_TK_CHECK, S_TK_UPD, S_TK_DUE,
    S_TK_DWAIT, S_TK_MUL, S_TK_DIVS, S_TK_SWAIT, S_TK_ROM, S_TK_SMUL, S_TK_FIN,
    S_TK_NEXT, S_TK_FLUSH
  } state_t;

  state_t state, state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.wr_sel = WR_TICK;
    cmd.div_op = DIV_SAMPLE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.req == REQ_REG) begin
          cmd.ack = 1'b1;
          if (sts.reg_ok) begin
            cmd.mem_wr   = 1'b1;
            cmd.wr_sel   = WR_REG;
            cmd.set_used = 1'b1;
          end
          state_next = S_IDLE;
        end else if (sts.req == REQ_CHG) begin
          if (sts.chg_ok) begin
            cmd.mem_rd = 1'b1;
            state_next = S_CHG_SCALE;
          end else begin
            cmd.ack    = 1'b1;
            state_next = S_IDLE;
          end
        end else if (sts.req == REQ_TICK) begin
          cmd.tick_init = 1'b1;
          state_next    = S_TK_CHECK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CHG_SCALE: begin
        state_next = S_CHG_WR;
      end
      S_CHG_WR: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_sel = WR_CHG;
        cmd.ack    = 1'b1;
        state_next = S_IDLE;
      end
      S_TK_CHECK: begin
        if (sts.used_cur) begin
          cmd.mem_rd  = 1'b1;
          cmd.rd_tick = 1'b1;
          state_next  = S_TK_UPD;
        end else begin
          state_next = S_TK_NEXT;
        end
      end
      S_TK_UPD: begin
        cmd.mem_wr = 1'b1;
        cmd.cnt_ld = 1'b1;
        state_next = S_TK_DUE;
      end
      S_TK_DUE: begin
        if (sts.step_zero || sts.cnt_zero) begin
          state_next = sts.cap ? S_TK_NEXT : S_TK_MUL;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_DUE;
          state_next    = S_TK_DWAIT;
        end
      end
      S_TK_DWAIT: begin
        if (sts.div_done) begin
          state_next = (sts.rem_zero && !sts.cap) ? S_TK_MUL : S_TK_NEXT;
        end
      end
      S_TK_MUL: begin
        cmd.mul    = 1'b1;
        state_next = sts.zero_period ? S_TK_FIN : S_TK_DIVS;
      end
      S_TK_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = S_TK_SWAIT;
      end
      S_TK_SWAIT: begin
        if (sts.div_done) state_next = sts.sine ? S_TK_ROM : S_TK_FIN;
      end
      S_TK_ROM: begin
        cmd.rom_rd = 1'b1;
        state_next = S_TK_SMUL;
      end
      S_TK_SMUL: begin
        cmd.smul   = 1'b1;
        state_next = S_TK_FIN;
      end
      S_TK_FIN: begin
        cmd.push   = 1'b1;
        state_next = S_TK_NEXT;
      end
      S_TK_NEXT: begin
        if (sts.last_slot) begin
          state_next = S_TK_FLUSH;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_TK_CHECK;
        end
      end
      S_TK_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

/* hw/rtl/multi_channel_waveform_generator_unit.sv */
// Register request: acknowledged from the decode state. Change: acknowledged after the counter
// preset, a reciprocal multiply registered in pre_prod and then pre_cnt. Tick: every slot is
// walked; a used slot is read and updated and, when due, also sampled (due check and
// sample share one bit-per-cycle divider); the next item is taken when busy falls.
// Synchronous active-high reset clears the used masks and the sequencer; no clearing pass.
// Results are strobed for one cycle and cannot be held off.
`default_nettype none
module multi_channel_waveform_generator_unit import wfg_pkg::*; #(
  parameter int SLOTS_PER_GROUP = 8,
  parameter int GROUPS          = 1,
  parameter int WAVE_KINDS      = 5,
  parameter int SINE_POINTS     = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [2:0]  wave_kind,
  input  wire logic [5:0]  slot_index,
  input  wire logic [15:0] amplitude,
  input  wire logic [15:0] step,
  input  wire logic [15:0] period,
  input  wire logic [9:0]  duty,
  input  wire logic [11:0] phase,
  input  wire logic [7:0]  signal_id,
  output logic             strobe,
  output logic             result_kind,
  output logic [2:0]       out_kind,
  output logic [5:0]       out_slot,
  output logic [7:0]       out_signal,
  output logic [15:0]      sample_value,
  output logic [2:0]       status,
  output logic             last
);

  cmd_t cmd;
  sts_t sts;

  wfg_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  wfg_datapath #(
    .SLOTS_PER_GROUP (SLOTS_PER_GROUP),
    .GROUPS          (GROUPS),
    .WAVE_KINDS      (WAVE_KINDS),
    .SINE_POINTS     (SINE_POINTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req_type     (req_type),
    .wave_kind    (wave_kind),
    .slot_index   (slot_index),
    .amplitude    (amplitude),
    .step         (step),
    .period       (period),
    .duty         (duty),
    .phase        (phase),
    .signal_id    (signal_id),
    .cmd          (cmd),
    .sts          (sts),
    .strobe       (strobe),
    .result_kind  (result_kind),
    .out_kind     (out_kind),
    .out_slot     (out_slot),
    .out_signal   (out_signal),
    .sample_value (sample_value),
    .status       (status),
    .last         (last)
  );

endmodule
`default_nettype wire

/* hw/rtl/wfg_checker.sv */
// Port-level checks of the waveform generator, bound to the top level.
// Depends on wfg_pkg for status codes.
`default_nettype none
module wfg_checker import wfg_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        strobe,
  input wire logic        result_kind,
  input wire logic [15:0] sample_value,
  input wire logic [2:0]  status,
  input wire logic        last
);

  // an acknowledgment is always the only result of its item
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !result_kind |-> last) else $error("ack without last");

  // an acknowledgment carries no sample
  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !result_kind |-> sample_value == 16'd0) else $error("ack with sample");

  // a sample reports ok status
  a_smp_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && result_kind |-> status == ST_OK) else $error("sample with status");

  // a transfer makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("not busy after transfer");

  // reset leaves the block quiet
  a_reset: assert property (@(posedge clk)
    rst |=> !strobe && !busy) else $error("activity after reset");

endmodule

bind multi_channel_waveform_generator_unit wfg_checker u_wfg_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .strobe       (strobe),
  .result_kind  (result_kind),
  .sample_value (sample_value),
  .status       (status),
  .last         (last)
);
`default_nettype wire

/* verif/wfg_sample_checker.sv */
// Checker for the waveform generator: predicts acknowledgments and samples for every
// accepted request and compares them with the strobed results. Depends on wfg_pkg.
module wfg_sample_checker import wfg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type,
  input  logic [2:0]  wave_kind,
  input  logic [5:0]  slot_index,
  input  logic [15:0] amplitude,
  input  logic [15:0] step,
  input  logic [15:0] period,
  input  logic [9:0]  duty,
  input  logic [11:0] phase,
  input  logic [7:0]  signal_id,
  input  logic        strobe,
  input  logic        result_kind,
  input  logic [2:0]  out_kind,
  input  logic [5:0]  out_slot,
  input  logic [7:0]  out_signal,
  input  logic [15:0] sample_value,
  input  logic [2:0]  status,
  input  logic        last,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBITS = 8;
  localparam int NKINDS = 5;
  localparam int NSLOTS = NKINDS * NBITS;
  localparam int NPOINTS = 1024;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct {
    logic        kind;
    logic [2:0]  wave;
    logic [5:0]  slot;
    logic [7:0]  sig;
    logic [15:0] value;
    logic [2:0]  st;
    logic        fin;
  } wave_result_t;

  wave_result_t due_results[$];

  logic [NBITS-1:0] used_mask[NKINDS];
  logic [15:0] amp_mem[NSLOTS];
  logic [15:0] step_mem[NSLOTS];
  logic [15:0] period_mem[NSLOTS];
  logic [9:0]  duty_mem[NSLOTS];
  logic [7:0]  sig_mem[NSLOTS];
  logic [15:0] count_mem[NSLOTS];
  int          sine_q15[NPOINTS];

  assign pending = due_results.size();

  // Build the quarter-wave series table once
  initial begin
    longint unsigned four, q, r, x, x2, t, s, v;
    for (int i = 0; i < NPOINTS; i++) begin
      four = 4 * i;
      q = four / NPOINTS;
      r = four - q * NPOINTS;
      if (q[0]) r = NPOINTS - r;
      x = HALF_PI_Q30 * r / NPOINTS;
      x2 = (x * x) >> 30;
      t = ONE_Q30 - x2 / 72;
      t = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      v = (s + 16384) >> 15;
      if (v > 32767) v = 32767;
      sine_q15[i] = (q >= 2) ? -int'(v) : int'(v);
    end
  end

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] wave_sample(int wave, int s);
    longint a, p, c, prod;
    a = longint'($signed(amp_mem[s]));
    p = period_mem[s];
    c = count_mem[s];
    if (p == 0) return 16'h0;
    case (wave)
      KIND_SINE: begin
        prod = a * sine_q15[(c * NPOINTS / p) % NPOINTS];
        return clamp16((prod + 16384) >>> 15);
      end
      KIND_PULSE: return clamp16((c < (longint'(duty_mem[s]) * p) / DUTY_MAX) ? a : 0);
      KIND_UP:    return clamp16(a * c / p);
      KIND_DOWN:  return clamp16(a * (p - c) / p);
      default:    return clamp16((c < (p >> 1)) ? a * c * 2 / p : a * (p - c) * 2 / p);
    endcase
  endfunction

  function automatic logic [2:0] param_code(logic [9:0] d, logic [11:0] ph);
    if (d > DUTY_MAX && ph > PHASE_MAX) return ST_BOTH_BAD;
    if (d > DUTY_MAX) return ST_DUTY_BAD;
    if (ph > PHASE_MAX) return ST_PHASE_BAD;
    return ST_OK;
  endfunction

  function automatic void push_result(logic k, logic [2:0] w, logic [5:0] sl,
                                      logic [7:0] sg, logic [15:0] v, logic [2:0] st,
                                      logic f);
    wave_result_t e;
    e.kind = k; e.wave = w; e.slot = sl; e.sig = sg; e.value = v; e.st = st; e.fin = f;
    due_results.push_back(e);
  endfunction

  function automatic void store_slot(int s);
    amp_mem[s] = amplitude;
    step_mem[s] = step;
    period_mem[s] = period;
    if (duty <= DUTY_MAX) duty_mem[s] = duty;
  endfunction

  // Work out the results of one accepted request
  function automatic void predict_request();
    int s, b, n, first;
    logic [15:0] c;
    logic [31:0] preset;
    case (req_type)
      REQ_REG: begin
        if (wave_kind >= NKINDS) begin
          push_result(1'b0, wave_kind, 6'd0, 8'd0, 16'd0, ST_RANGE, 1'b1);
        end else if (&used_mask[wave_kind]) begin
          push_result(1'b0, wave_kind, 6'd0, 8'd0, 16'd0, ST_FULL, 1'b1);
        end else begin
          first = 0;
          while (used_mask[wave_kind][first]) first++;
          used_mask[wave_kind][first] = 1'b1;
          s = wave_kind * NBITS + first;
          store_slot(s);
          sig_mem[s] = signal_id;
          count_mem[s] = 16'd0;
          push_result(1'b0, wave_kind, 6'(first), signal_id, 16'd0,
                      param_code(duty, phase), 1'b1);
        end
      end
      REQ_CHG: begin
        b = slot_index & BIT_MASK;
        if (wave_kind >= NKINDS || (slot_index >> 4) >= 1) begin
          push_result(1'b0, wave_kind, slot_index, 8'd0, 16'd0, ST_RANGE, 1'b1);
        end else if (b >= NBITS || !used_mask[wave_kind][b]) begin
          push_result(1'b0, wave_kind, slot_index, 8'd0, 16'd0, ST_UNUSED, 1'b1);
        end else begin
          s = wave_kind * NBITS + b;
          store_slot(s);
          preset = 32'(phase) * 32'(period) / PHASE_MAX;
          count_mem[s] = preset[15:0];
          push_result(1'b0, wave_kind, slot_index, sig_mem[s], 16'd0,
                      param_code(duty, phase), 1'b1);
        end
      end
      REQ_TICK: begin
        n = 0;
        for (int w = 0; w < NKINDS; w++) begin
          for (int k = 0; k < NBITS; k++) begin
            if (used_mask[w][k]) begin
              s = w * NBITS + k;
              c = count_mem[s] + 16'd1;
              if (c >= period_mem[s]) c = 16'd0;
              count_mem[s] = c;
              if ((step_mem[s] == 0 || c == 0 || (c % step_mem[s]) == 0) &&
                  n < MAX_RESULTS) begin
                push_result(1'b1, 3'(w), 6'(k), sig_mem[s], wave_sample(w, s), ST_OK, 1'b0);
                n++;
              end
            end
          end
        end
        if (n > 0) due_results[$].fin = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void flag(string what, longint e, longint a);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, e, a);
  endfunction

  // Compare strobed results first, then predict the request taken at this edge
  always @(posedge clk) begin
    wave_result_t e;
    if (rst) begin
      for (int w = 0; w < NKINDS; w++) used_mask[w] = '0;
      for (int s = 0; s < NSLOTS; s++) begin
        amp_mem[s] = 0; step_mem[s] = 0; period_mem[s] = 0;
        duty_mem[s] = 0; sig_mem[s] = 0; count_mem[s] = 0;
      end
      due_results.delete();
    end else begin
      if (strobe) begin
        if (due_results.size() == 0) begin
          flag("unexpected result, slot", -1, out_slot);
        end else begin
          e = due_results.pop_front();
          if (result_kind !== e.kind) flag("result_kind", e.kind, result_kind);
          if (out_kind !== e.wave) flag("out_kind", e.wave, out_kind);
          if (out_slot !== e.slot) flag("out_slot", e.slot, out_slot);
          if (out_signal !== e.sig) flag("out_signal", e.sig, out_signal);
          if (sample_value !== e.value)
            flag("sample_value", $signed(e.value), $signed(sample_value));
          if (status !== e.st) flag("status", e.st, status);
          if (last !== e.fin) flag("last", e.fin, last);
        end
      end
      if (start && !busy) predict_request();
    end
  end

  initial fail_count = 0;
endmodule

/* verif/tb_multi_channel_waveform_generator_unit.sv */
// Top of the waveform generator testbench: clock, reset, request stimulus and verdict.
// Depends on wfg_pkg, the generator RTL and wfg_sample_checker.
module tb_multi_channel_waveform_generator_unit;
  import wfg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_ITEMS = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = '0;
  logic [2:0]  wave_kind = '0;
  logic [5:0]  slot_index = '0;
  logic [15:0] amplitude = '0;
  logic [15:0] step = '0;
  logic [15:0] period = '0;
  logic [9:0]  duty = '0;
  logic [11:0] phase = '0;
  logic [7:0]  signal_id = '0;
  logic        strobe, result_kind, last;
  logic [2:0]  out_kind, status;
  logic [5:0]  out_slot;
  logic [7:0]  out_signal;
  logic [15:0] sample_value;
  int          fail_count, pending;
  int          cycles = 0;
  bit          burst = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  multi_channel_waveform_generator_unit dut (.*);
  wfg_sample_checker checker_i (.*);

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[multi_channel_waveform_generator_unit] ERROR");
      $finish;
    end
  end

  // Present one request, hold it until transfer, then idle a random gap unless in a burst
  task automatic send(logic [1:0] rq, logic [2:0] k, logic [5:0] idx, logic [15:0] a,
                      logic [15:0] st, logic [15:0] p, logic [9:0] d, logic [11:0] ph,
                      logic [7:0] sig);
    int gap;
    start <= 1'b1;
    req_type <= rq; wave_kind <= k; slot_index <= idx; amplitude <= a;
    step <= st; period <= p; duty <= d; phase <= ph; signal_id <= sig;
    do @(negedge clk); while (busy);
    @(posedge clk);
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off requests until every expected result has come, then resume at a rising edge
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
  endtask

  // Random request, weighted toward valid slots and short periods
  task automatic send_random();
    int pick;
    logic [1:0]  rq;
    logic [2:0]  k;
    logic [5:0]  idx;
    logic [15:0] st, p;
    logic [9:0]  d;
    logic [11:0] ph;
    pick = $urandom_range(0, 99);
    rq = (pick < 20) ? REQ_REG : (pick < 45) ? REQ_CHG : (pick < 96) ? REQ_TICK : 2'd3;
    k = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    idx = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
    p = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
    st = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    d = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, DUTY_MAX));
    ph = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, PHASE_MAX));
    send(rq, k, idx, 16'($urandom), st, p, d, ph, 8'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, bad parameters, range, unused and full errors, ignored request, ticks
    send(REQ_REG, KIND_SINE, 0, 16'h7FFF, 0, 8, 500, 0, 8'hFF);
    send(REQ_REG, KIND_PULSE, 0, 16'h8000, 0, 10, 300, 900, 1);
    send(REQ_REG, KIND_UP, 0, 1000, 2, 0, 10'h3FF, 0, 2);
    send(REQ_REG, KIND_DOWN, 0, 16'hFFFB, 16'hFFFF, 16'hFFFF, 0, 12'hFFF, 3);
    send(REQ_REG, KIND_TRI, 0, 20000, 3, 7, 1001, 3601, 4);
    send(REQ_REG, 3'd5, 0, 1, 1, 1, 0, 0, 5);
    send(REQ_REG, 3'd7, 0, 1, 1, 1, 0, 0, 6);
    send(REQ_CHG, KIND_SINE, 0, 16'h8000, 0, 100, 0, 1800, 7);
    send(REQ_CHG, KIND_SINE, 16, 1, 1, 1, 0, 0, 0);
    send(REQ_CHG, KIND_SINE, 8, 1, 1, 1, 0, 0, 0);
    send(REQ_CHG, KIND_SINE, 5, 1, 1, 1, 0, 0, 0);
    send(REQ_CHG, 3'd6, 0, 1, 1, 1, 0, 0, 0);
    send(REQ_CHG, KIND_DOWN, 0, 16'h7FFF, 0, 16'hFFFF, 0, 12'(PHASE_MAX), 0);
    send(2'd3, KIND_SINE, 0, 0, 0, 0, 0, 0, 0);
    repeat (3) send(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++)
      send(REQ_REG, KIND_PULSE, 0, 16'($urandom), 0, 16'(i + 1), 10'(i * 140), 0, 8'(i));
    send(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0);

    // Random traffic, with stretches of back-to-back requests and one full drain
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      if (i == RANDOM_ITEMS / 2) wait_drained();
      send_random();
    end
    start <= 1'b0;

    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[multi_channel_waveform_generator_unit] OK");
    else
      $display("[multi_channel_waveform_generator_unit] ERROR");
    $finish;
  end
endmodule

/* multi_channel_waveform_generator_unit.f */
hw/rtl/wfg_pkg.sv
hw/rtl/wfg_div.sv
hw/rtl/wfg_datapath.sv
hw/rtl/wfg_ctrl.sv
hw/rtl/multi_channel_waveform_generator_unit.sv
hw/rtl/wfg_checker.sv
verif/wfg_sample_checker.sv
verif/tb_multi_channel_waveform_generator_unit.sv
